/* sv/bucketed_indexed_list_macros.svh */
// Assertion macros for the bucketed list.
`ifndef BUCKETED_INDEXED_LIST_MACROS_SVH
`define BUCKETED_INDEXED_LIST_MACROS_SVH
`ifndef SYNTHESIS
`define BIL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define BIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BIL_ASSERT(label, clk, rst_n, prop)
`define BIL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/bil_pkg.sv */
`default_nettype none
package bil_pkg;
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_GET    = 2'd2;
  localparam logic [1:0] REQ_SET    = 2'd3;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
endpackage
`default_nettype wire

/* sv/bil_store.sv */
`default_nettype none
// Element memory: one write port, one registered read port.
module bil_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned DW    = 32,
  parameter int unsigned AW    = 12
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* sv/bucketed_indexed_list.sv */
`default_nettype none
// Bucketed positional list. Requests enter on the s_axis channel, with
// tdata = {new_value, position, req_type} from the high bit down. Each request
// yields one result on m_axis, tdata = {status, list_length, read_value}.
// Set and range errors pass through S_DEC and S_OUT, and get also reads in
// S_GET. Insert and pop also walk the bucket length table (S_WALK, S_WALK2)
// and shift the list tail in the element memory one element at a time,
// reading it (S_RD, S_PRD) and then writing it (S_MOVE, S_PMOVE).
// Elements are stored contiguously, so bucket bookkeeping only sets when
// an insert is refused for lack of a bucket slot; contents follow list order.
// After reset the list is empty and the bucket tables are in reset order.
// A result waits in the output register while m_axis_tready is low; the
// next request is accepted only after the result is taken.
module bucketed_indexed_list #(
  parameter int unsigned CAPACITY    = 4096,
  parameter int unsigned BUCKET_SIZE = 1024,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // req_type[1:0], position[14:2], new_value[46:15]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata   // read_value[31:0], list_length[44:32], status[46:45]
);
  import bil_pkg::*;
  `include "bucketed_indexed_list_macros.svh"

  localparam int unsigned NB  = ((2*CAPACITY)/BUCKET_SIZE) > 0 ? (2*CAPACITY)/BUCKET_SIZE : 1;
  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned BW  = NB > 1 ? $clog2(NB) : 1;
  localparam int unsigned CW  = $clog2(NB+1);
  localparam int unsigned LW  = $clog2(BUCKET_SIZE+2);
  localparam int unsigned DWU = DATA_WIDTH < 32 ? DATA_WIDTH : 32;

  localparam logic [3:0] S_IDLE = 4'd0, S_WALK = 4'd1, S_DEC = 4'd2, S_RD = 4'd3,
    S_MOVE = 4'd4, S_FIN = 4'd5, S_OUT = 4'd6, S_GET = 4'd7, S_PRD = 4'd8,
    S_PMOVE = 4'd9, S_PFIN = 4'd10, S_WALK2 = 4'd11;

  logic [3:0]  st_q, st_d;
  logic [1:0]  kind_q;
  logic [12:0] pos_q, cnt_q;
  logic [31:0] val_q;
  logic [LW-1:0] blen_q [NB];
  logic [BW-1:0] bord_q [NB];
  logic [CW-1:0] bcnt_q;
  logic [BW-1:0] wi_q;
  logic [12:0]   rem_q, ptr_q;
  logic [31:0]   rv_q;
  logic [12:0]   olen_q;
  logic [1:0]    ost_q;
  logic          ov_q;

  logic          we;
  logic [AW-1:0] wa, ra;
  logic [DATA_WIDTH-1:0] wd, rd;

  bil_store #(.DEPTH(CAPACITY), .DW(DATA_WIDTH), .AW(AW)) u_store (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd));

  assign s_axis_tready = (st_q == S_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, ost_q, olen_q, rv_q};

  logic [LW-1:0] cur_len;
  logic [BW-1:0] cur_slot;
  assign cur_slot = bord_q[wi_q];
  assign cur_len  = blen_q[cur_slot];

  // Memory port control.
  always_comb begin
    we = 1'b0;
    wa = ptr_q[AW-1:0];
    wd = rd;
    ra = ptr_q[AW-1:0];
    unique case (st_q)
      S_MOVE: begin
        we = 1'b1;
        wa = AW'(ptr_q + 13'd1);
      end
      S_FIN: begin
        we = 1'b1;
        wa = pos_q[AW-1:0];
        wd = DATA_WIDTH'(val_q);
      end
      S_PMOVE: begin
        we = 1'b1;
        wa = AW'(ptr_q - 13'd1);
      end
      S_DEC: begin
        we = (kind_q == REQ_SET) && (pos_q < cnt_q);
        wa = pos_q[AW-1:0];
        wd = DATA_WIDTH'(val_q);
        ra = pos_q[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
      bcnt_q <= '0;
      ov_q  <= 1'b0;
      kind_q <= '0;
      pos_q  <= '0;
      val_q  <= '0;
      rem_q  <= '0;
      ptr_q  <= '0;
      wi_q   <= '0;
      rv_q   <= '0;
      olen_q <= '0;
      ost_q  <= '0;
      for (int i = 0; i < NB; i++) begin
        blen_q[i] <= '0;
        bord_q[i] <= BW'(i);
      end
    end else begin
      if (ov_q && m_axis_tready) ov_q <= 1'b0;
      unique case (st_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          kind_q <= s_axis_tdata[1:0];
          pos_q  <= s_axis_tdata[14:2];
          val_q  <= 32'(s_axis_tdata[15 +: DWU]);
          rem_q  <= s_axis_tdata[14:2];
          wi_q   <= '0;
          st_q   <= (s_axis_tdata[1:0] == REQ_INSERT && bcnt_q != 0
                     && s_axis_tdata[14:2] <= cnt_q && cnt_q < 13'(CAPACITY))
                    ? S_WALK : S_DEC;
        end
        S_WALK: begin
          // Find the logical bucket; an append goes to the last bucket.
          if (13'(cur_len) > rem_q && !(pos_q == cnt_q)) st_q <= S_DEC;
          else if (32'(wi_q) + 1 >= 32'(bcnt_q)) st_q <= S_DEC;
          else begin
            rem_q <= rem_q - 13'(cur_len);
            wi_q  <= wi_q + 1'b1;
          end
        end
        S_DEC: begin
          rv_q <= '0;
          ost_q <= ST_OK;
          olen_q <= cnt_q;
          if (kind_q == REQ_INSERT) begin
            if (pos_q > cnt_q) begin ost_q <= ST_RANGE; st_q <= S_OUT; end
            else if (cnt_q >= 13'(CAPACITY)) begin ost_q <= ST_FULL; st_q <= S_OUT; end
            else if (bcnt_q == 0) begin
              blen_q[bord_q[0]] <= LW'(1);
              bcnt_q <= CW'(1);
              ptr_q <= pos_q;
              st_q <= S_FIN;
            end else if (32'(cur_len) + 1 > BUCKET_SIZE && 32'(bcnt_q) >= NB) begin
              ost_q <= ST_FULL; st_q <= S_OUT;
            end else begin
              if (32'(cur_len) + 1 > BUCKET_SIZE) begin
                for (int i = 1; i < NB; i++)
                  if (i > 32'(wi_q) + 1 && i <= 32'(bcnt_q)) bord_q[i] <= bord_q[i-1];
                bord_q[wi_q + 1'b1] <= bord_q[bcnt_q[BW-1:0]];
                blen_q[bord_q[bcnt_q[BW-1:0]]] <= LW'(32'(cur_len) + 1 - BUCKET_SIZE/2);
                blen_q[cur_slot] <= LW'(BUCKET_SIZE/2);
                bcnt_q <= bcnt_q + 1'b1;
              end else blen_q[cur_slot] <= cur_len + 1'b1;
              ptr_q <= cnt_q - 13'd1;
              st_q <= (cnt_q == pos_q) ? S_FIN : S_RD;
            end
          end else if (pos_q >= cnt_q) begin
            ost_q <= ST_RANGE; st_q <= S_OUT;
          end else if (kind_q == REQ_SET) st_q <= S_OUT;
          else st_q <= S_GET;
        end
        S_RD: st_q <= S_MOVE;
        S_MOVE: begin
          if (ptr_q == pos_q) st_q <= S_FIN;
          else begin ptr_q <= ptr_q - 13'd1; st_q <= S_RD; end
        end
        S_FIN: begin
          cnt_q <= cnt_q + 13'd1;
          olen_q <= cnt_q + 13'd1;
          st_q <= S_OUT;
        end
        S_GET: begin
          rv_q <= 32'(rd);
          if (kind_q == REQ_POP) begin
            ptr_q <= pos_q + 13'd1;
            st_q <= S_WALK2;
            wi_q <= '0;
          end else st_q <= S_OUT;
        end
        S_WALK2: begin
          if (13'(cur_len) > rem_q || 32'(wi_q) + 1 >= 32'(bcnt_q)) begin
            if (cur_len == LW'(1)) begin
              for (int i = 0; i < NB - 1; i++)
                if (i >= 32'(wi_q) && i + 1 < 32'(bcnt_q)) bord_q[i] <= bord_q[i+1];
              bord_q[bcnt_q[BW-1:0] - 1'b1] <= cur_slot;
              bcnt_q <= bcnt_q - 1'b1;
            end
            if (cur_len != 0) blen_q[cur_slot] <= cur_len - 1'b1;
            st_q <= (ptr_q >= cnt_q) ? S_PFIN : S_PRD;
          end else begin
            rem_q <= rem_q - 13'(cur_len);
            wi_q  <= wi_q + 1'b1;
          end
        end
        S_PRD: st_q <= S_PMOVE;
        S_PMOVE: begin
          if (ptr_q + 13'd1 >= cnt_q) st_q <= S_PFIN;
          else begin ptr_q <= ptr_q + 13'd1; st_q <= S_PRD; end
        end
        S_PFIN: begin
          cnt_q <= cnt_q - 13'd1;
          olen_q <= cnt_q - 13'd1;
          st_q <= S_OUT;
        end
        S_OUT: begin
          ov_q <= 1'b1;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `BIL_ASSERT(a_cnt_cap, clk_i, rst_ni, cnt_q <= 13'(CAPACITY))
  `BIL_ASSERT(a_bcnt, clk_i, rst_ni, 32'(bcnt_q) <= NB)
  `BIL_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  `BIL_ASSERT(a_busy, clk_i, rst_ni, !(ov_q && s_axis_tready))
endmodule
`default_nettype wire

/* verif/bucketed_indexed_list_test.sv */
`default_nettype none
module bucketed_indexed_list_test;
  import bil_pkg::*;

  localparam int unsigned CAPACITY    = 4096;
  localparam int unsigned BUCKET_SIZE = 1024;
  localparam int unsigned MAX_BUCKETS = 8;
  localparam int unsigned IDLE_LIMIT  = 60000;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] length;
    logic [31:0] value;
  } list_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] req_data = '0;
  logic        m_axis_tvalid;
  logic        rsp_ready = 1'b0;
  logic [47:0] m_axis_tdata;

  // Shadow of the list: contents in list order and bucket lengths in bucket order.
  logic [31:0]  shadow_values[$];
  int unsigned  shadow_buckets[$];
  list_result_t pending_results[$];

  int errors = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  int long_hold = 0;
  bit quiet = 1'b0;

  bucketed_indexed_list #(
    .CAPACITY(CAPACITY),
    .BUCKET_SIZE(BUCKET_SIZE),
    .DATA_WIDTH(32)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(req_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(req_data),    // req_type[1:0], position[14:2], new_value[46:15]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(rsp_ready),
    .m_axis_tdata(m_axis_tdata) // read_value[31:0], list_length[44:32], status[46:45]
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= 40) $display("mismatch: %s", msg);
  endtask

  // A boundary position belongs to the later bucket.
  function automatic int unsigned bucket_of(input int unsigned k);
    int unsigned i;
    int unsigned rest;
    rest = k;
    for (i = 0; i < shadow_buckets.size(); i++) begin
      if (rest < shadow_buckets[i]) return i;
      rest -= shadow_buckets[i];
    end
    return (shadow_buckets.size() > 0) ? shadow_buckets.size() - 1 : 0;
  endfunction

  function automatic list_result_t apply_request(input logic [1:0] kind, input logic [12:0] pos,
                                                 input logic [31:0] val);
    list_result_t r;
    int unsigned  k;
    int unsigned  n;
    int unsigned  b;
    r = '0;
    k = 32'(pos);
    n = shadow_values.size();
    if (kind == REQ_INSERT) begin
      if (k > n) r.status = ST_RANGE;
      else if (n >= CAPACITY) r.status = ST_FULL;
      else if (shadow_buckets.size() == 0) begin
        shadow_buckets.insert(0, 1);
        shadow_values.insert(0, val);
      end else begin
        b = (k == n) ? shadow_buckets.size() - 1 : bucket_of(k);
        if (shadow_buckets[b] + 1 > BUCKET_SIZE && shadow_buckets.size() >= MAX_BUCKETS) begin
          r.status = ST_FULL;
        end else begin
          shadow_values.insert(k, val);
          shadow_buckets[b]++;
          if (shadow_buckets[b] > BUCKET_SIZE) begin
            shadow_buckets.insert(b + 1, shadow_buckets[b] - BUCKET_SIZE / 2);
            shadow_buckets[b] = BUCKET_SIZE / 2;
          end
        end
      end
    end else if (k >= n) begin
      r.status = ST_RANGE;
    end else if (kind == REQ_POP) begin
      r.value = shadow_values[k];
      b = bucket_of(k);
      shadow_values.delete(k);
      shadow_buckets[b]--;
      if (shadow_buckets[b] == 0) shadow_buckets.delete(b);
    end else if (kind == REQ_GET) begin
      r.value = shadow_values[k];
    end else begin
      shadow_values[k] = val;
    end
    r.length = 13'(shadow_values.size());
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the item is accepted.
  task automatic send_request(input logic [1:0] kind, input int unsigned pos,
                              input logic [31:0] val);
    list_result_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_data  <= {1'b0, val, pos[12:0], kind};
    do @(posedge clk_i); while (!s_axis_tready);
    r = apply_request(kind, pos[12:0], val);
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic send_random(input int unsigned max_len);
    logic [1:0]  kind;
    int unsigned n;
    int unsigned pos;
    int unsigned pick;
    n = shadow_values.size();
    kind = 2'($urandom_range(0, 3));
    if (n >= max_len && kind == REQ_INSERT) kind = REQ_POP;
    pick = $urandom_range(0, 99);
    if (pick < 85) pos = (kind == REQ_INSERT) ? $urandom_range(0, n) : $urandom_range(0, n ? n - 1 : 0);
    else if (pick < 95) pos = n + $urandom_range(0, 3);
    else pos = $urandom_range(0, 8191);
    send_request(kind, pos, $urandom);
  endtask

  task automatic drain_list;
    while (shadow_values.size() > 0) send_request(REQ_POP, shadow_values.size() - 1, $urandom);
  endtask

  task automatic test_directed;
    send_request(REQ_GET, 0, 32'h0);
    send_request(REQ_POP, 0, 32'h0);
    send_request(REQ_SET, 0, 32'h1234_5678);
    send_request(REQ_INSERT, 1, 32'h1);
    send_request(REQ_INSERT, 0, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 0, 32'h0000_0000);
    send_request(REQ_INSERT, 2, 32'hA5A5_5A5A);
    send_request(REQ_INSERT, 1, 32'h8000_0001);
    send_request(REQ_GET, 0, 32'h0);
    send_request(REQ_GET, 1, 32'h0);
    send_request(REQ_GET, 3, 32'h0);
    send_request(REQ_GET, 4, 32'h0);
    send_request(REQ_SET, 2, 32'h5A5A_A5A5);
    send_request(REQ_GET, 2, 32'h0);
    send_request(REQ_GET, 8191, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 8191, 32'hFFFF_FFFF);
    send_request(REQ_POP, 1, 32'h0);
    send_request(REQ_POP, 2, 32'h0);
    send_request(REQ_SET, 2, 32'h0);
    send_request(REQ_POP, 0, 32'h0);
    send_request(REQ_POP, 0, 32'h0);
    send_request(REQ_POP, 0, 32'h0);
  endtask

  task automatic test_random(input int unsigned count, input int unsigned max_len);
    repeat (count) send_random(max_len);
  endtask

  // Appends until one bucket grows past its size and splits, then works on
  // both sides of the new boundary.
  task automatic test_bucket_split;
    drain_list();
    while (shadow_buckets.size() < 2) send_request(REQ_INSERT, shadow_values.size(), $urandom);
    send_request(REQ_GET, BUCKET_SIZE / 2 - 1, 0);
    send_request(REQ_GET, BUCKET_SIZE / 2, 0);
    send_request(REQ_INSERT, BUCKET_SIZE / 2, 32'h1357_9BDF);
    send_request(REQ_SET, BUCKET_SIZE / 2, 32'h2468_ACE0);
    send_request(REQ_GET, BUCKET_SIZE / 2, 0);
    send_request(REQ_POP, BUCKET_SIZE / 2, 0);
    send_request(REQ_POP, BUCKET_SIZE / 2 - 1, 0);
    send_request(REQ_GET, shadow_values.size(), 0);
    send_request(REQ_INSERT, shadow_values.size() + 1, 0);
  endtask

  task automatic test_backpressure;
    long_hold = 400;
    repeat (20) send_random(30);
  endtask

  task automatic test_quiet_tail;
    quiet = 1'b1;
    repeat (30) send_random(12);
  endtask

  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (m_axis_tvalid && rsp_ready) begin
      got = m_axis_tdata[46:0];
      if (pending_results.size() == 0) begin
        report("result arrived with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value)
          report($sformatf("read_value %h, expected %h", got.value, want.value));
        if (got.length !== want.length)
          report($sformatf("list_length %0d, expected %0d", got.length, want.length));
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
      end
    end
    if ((m_axis_tvalid && rsp_ready) || (req_valid && s_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver side: short random holds, and one long hold when asked for.
  always @(posedge clk_i) begin
    if (long_hold > 0) begin
      hold_left = long_hold;
      long_hold = 0;
    end
    if (hold_left > 0 && !quiet) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(1, 8) - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(70, 16);
    test_backpressure();
    test_bucket_split();
    test_quiet_tail();
    req_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
